// ===== design/fsc_pkg.sv =====
// fsc_pkg: shared types and constants for the frustum sphere cull block.
// Used by fsc_cell and by the frustum_sphere_cull top level.
package fsc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int IDX_W      = 3;
  localparam int NORM_W     = 16;
  localparam int COORD_W    = 32;
  localparam int RAD_W      = 31;
  localparam int PROD_W     = NORM_W + COORD_W;
  // three products, an offset and a radius, all at 2^-30 scale
  localparam int SUM_W      = PROD_W + 3;
  localparam int FRAC_SHIFT = 14;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [IDX_W-1:0]           plane_index;
    logic signed [NORM_W-1:0]   normal_x;
    logic signed [NORM_W-1:0]   normal_y;
    logic signed [NORM_W-1:0]   normal_z;
    logic signed [COORD_W-1:0]  plane_offset;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;
    logic [RAD_W-1:0]           sphere_radius;
    logic                       visible;
  } beat_t;

endpackage

// ===== design/fsc_cell.sv =====
// fsc_cell: one clip plane of the cull chain, two stages (multiply, then sum and test).
// Depends on fsc_pkg for the beat type and widths.
module fsc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [fsc_pkg::IDX_W-1:0]  cell_id,
  input  logic                       in_valid,
  input  fsc_pkg::beat_t             in_beat,
  output logic                       in_ready,
  output logic                       out_valid,
  output fsc_pkg::beat_t             out_beat,
  input  logic                       out_ready
);

  logic signed [fsc_pkg::NORM_W-1:0]  normal_x;
  logic signed [fsc_pkg::NORM_W-1:0]  normal_y;
  logic signed [fsc_pkg::NORM_W-1:0]  normal_z;
  logic signed [fsc_pkg::COORD_W-1:0] offset;

  logic                               a_valid;
  fsc_pkg::beat_t                     a_beat;
  logic signed [fsc_pkg::PROD_W-1:0]  a_px;
  logic signed [fsc_pkg::PROD_W-1:0]  a_py;
  logic signed [fsc_pkg::PROD_W-1:0]  a_pz;
  logic signed [fsc_pkg::COORD_W-1:0] a_offset;

  logic                               b_valid;
  fsc_pkg::beat_t                     b_beat;
  fsc_pkg::beat_t                     b_beat_next;

  logic                               en_a;
  logic                               en_b;
  logic                               take;
  logic                               load_hit;
  logic signed [fsc_pkg::PROD_W-1:0]  mul_x;
  logic signed [fsc_pkg::PROD_W-1:0]  mul_y;
  logic signed [fsc_pkg::PROD_W-1:0]  mul_z;
  logic [fsc_pkg::SUM_W-1:0]          sum;

  // a stage may advance when it is empty or its successor advances
  assign en_b     = !b_valid || out_ready;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;
  assign take     = in_valid && en_a;
  assign load_hit = take && (in_beat.cmd == fsc_pkg::CMD_LOAD) &&
                    (in_beat.plane_index == cell_id);

  assign mul_x = normal_x * in_beat.center_x;
  assign mul_y = normal_y * in_beat.center_y;
  assign mul_z = normal_z * in_beat.center_z;

  assign sum = fsc_pkg::SUM_W'(a_px) + fsc_pkg::SUM_W'(a_py) + fsc_pkg::SUM_W'(a_pz)
             - (fsc_pkg::SUM_W'(a_offset) << fsc_pkg::FRAC_SHIFT)
             + (fsc_pkg::SUM_W'({1'b0, a_beat.sphere_radius}) << fsc_pkg::FRAC_SHIFT);

  always_comb begin
    b_beat_next         = a_beat;
    // drop visibility on a negative signed distance
    b_beat_next.visible = a_beat.visible & ~sum[fsc_pkg::SUM_W-1];
  end

  // plane store: a load beat writes it as it enters, so later tests see the new plane
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= '0;
      offset   <= '0;
    end else if (load_hit) begin
      normal_x <= in_beat.normal_x;
      normal_y <= in_beat.normal_y;
      normal_z <= in_beat.normal_z;
      offset   <= in_beat.plane_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= in_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_beat   <= in_beat;
      a_px     <= mul_x;
      a_py     <= mul_y;
      a_pz     <= mul_z;
      a_offset <= offset;
    end
    if (en_b) begin
      b_beat <= b_beat_next;
    end
  end

  assign out_valid = b_valid;
  assign out_beat  = b_beat;

  a_plane_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !load_hit |=> $stable(normal_x) && $stable(normal_y) && $stable(normal_z) &&
                  $stable(offset))
    else $error("plane store changed without a load beat for this cell");

  a_stage_a_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !en_b |=> a_valid && $stable(a_px) && $stable(a_beat))
    else $error("multiply stage lost or changed a blocked beat");

  a_stage_b_holds: assert property (@(posedge clk) disable iff (rst)
    b_valid && !out_ready |=> b_valid && $stable(b_beat))
    else $error("sum stage lost or changed a blocked beat");

endmodule

// ===== design/frustum_sphere_cull.sv =====
// frustum_sphere_cull: top level, a chain of plane cells followed by a result register.
// Depends on fsc_pkg and fsc_cell.
//
// Every beat, load or test, travels down a chain of six plane cells, one per clip
// plane, two register stages each, and then an output register that holds the test
// result; the block takes one beat per cycle when nothing stalls. A load beat
// writes its plane as it passes that plane's cell, so loads and tests take effect
// strictly in arrival order; a load to an index of six or more changes nothing and,
// like every load, yields no result. Each cell multiplies the stored normal by the
// centre in its first stage and, in its second, subtracts the offset and adds the
// radius; a sum of exactly zero counts as visible. Stalls fill empty stages first,
// so new beats are still taken while a result waits.
module frustum_sphere_cull (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               cmd,
  input  logic [fsc_pkg::IDX_W-1:0]          plane_index,
  input  logic signed [fsc_pkg::NORM_W-1:0]  normal_x,
  input  logic signed [fsc_pkg::NORM_W-1:0]  normal_y,
  input  logic signed [fsc_pkg::NORM_W-1:0]  normal_z,
  input  logic signed [fsc_pkg::COORD_W-1:0] plane_offset,
  input  logic signed [fsc_pkg::COORD_W-1:0] center_x,
  input  logic signed [fsc_pkg::COORD_W-1:0] center_y,
  input  logic signed [fsc_pkg::COORD_W-1:0] center_z,
  input  logic [fsc_pkg::RAD_W-1:0]          sphere_radius,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               visible
);

  logic           chain_valid [fsc_pkg::NUM_PLANES+1];
  logic           chain_ready [fsc_pkg::NUM_PLANES+1];
  fsc_pkg::beat_t chain_beat  [fsc_pkg::NUM_PLANES+1];
  logic           out_en;

  always_comb begin
    chain_beat[0].cmd           = fsc_pkg::cmd_t'(cmd);
    chain_beat[0].plane_index   = plane_index;
    chain_beat[0].normal_x      = normal_x;
    chain_beat[0].normal_y      = normal_y;
    chain_beat[0].normal_z      = normal_z;
    chain_beat[0].plane_offset  = plane_offset;
    chain_beat[0].center_x      = center_x;
    chain_beat[0].center_y      = center_y;
    chain_beat[0].center_z      = center_z;
    chain_beat[0].sphere_radius = sphere_radius;
    chain_beat[0].visible       = 1'b1;
  end

  assign chain_valid[0] = item_valid;
  assign item_stall     = !chain_ready[0];

  for (genvar i = 0; i < fsc_pkg::NUM_PLANES; i++) begin : g_cell
    fsc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (fsc_pkg::IDX_W'(i)),
      .in_valid  (chain_valid[i]),
      .in_beat   (chain_beat[i]),
      .in_ready  (chain_ready[i]),
      .out_valid (chain_valid[i+1]),
      .out_beat  (chain_beat[i+1]),
      .out_ready (chain_ready[i+1])
    );
  end

  assign out_en = !result_valid || !result_stall;
  assign chain_ready[fsc_pkg::NUM_PLANES] = out_en;

  // drop load beats at the end of the chain; only tests produce a result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= chain_valid[fsc_pkg::NUM_PLANES] &&
                      (chain_beat[fsc_pkg::NUM_PLANES].cmd == fsc_pkg::CMD_TEST);
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      visible <= chain_beat[fsc_pkg::NUM_PLANES].visible;
    end
  end

endmodule

// ===== test/frustum_sphere_cull_tb.sv =====
// frustum_sphere_cull_tb: self-checking bench for the six-plane sphere culling block.
// Predicts visibility per test beat from its own plane store and checks every result beat.
// Depends on fsc_pkg and the frustum_sphere_cull design.
`timescale 1ns / 100ps

module frustum_sphere_cull_tb;

  localparam int TOTAL_BEATS = 1850;
  localparam int CALM_TAIL   = 150;   // beats left when idling stops
  localparam int PAUSE_AT    = 900;   // accepted beats before the sender drains the block
  localparam int LONG_AT     = 200;   // results seen before the long receiver hold
  localparam int LONG_HOLD   = 300;
  localparam int CMIN        = 32'h8000_0000;
  localparam int CMAX        = 32'h7fff_ffff;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               item_valid = 1'b0;
  logic                               item_stall;
  logic                               cmd = 1'b0;
  logic [fsc_pkg::IDX_W-1:0]          plane_index = '0;
  logic signed [fsc_pkg::NORM_W-1:0]  normal_x = '0;
  logic signed [fsc_pkg::NORM_W-1:0]  normal_y = '0;
  logic signed [fsc_pkg::NORM_W-1:0]  normal_z = '0;
  logic signed [fsc_pkg::COORD_W-1:0] plane_offset = '0;
  logic signed [fsc_pkg::COORD_W-1:0] center_x = '0;
  logic signed [fsc_pkg::COORD_W-1:0] center_y = '0;
  logic signed [fsc_pkg::COORD_W-1:0] center_z = '0;
  logic [fsc_pkg::RAD_W-1:0]          sphere_radius = '0;
  logic                               result_valid;
  logic                               result_stall = 1'b0;
  logic                               visible;

  frustum_sphere_cull dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .plane_index(plane_index),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .plane_offset(plane_offset),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .sphere_radius(sphere_radius),
    .result_valid(result_valid), .result_stall(result_stall),
    .visible(visible)
  );

  always #5 clk = ~clk;

  fsc_pkg::beat_t beat_q[$];
  logic           visible_q[$];
  fsc_pkg::beat_t cur_beat;
  longint         plane_n[fsc_pkg::NUM_PLANES][3];
  longint         plane_d[fsc_pkg::NUM_PLANES];
  int             n_beats = 0;
  int             n_sent = 0;
  int             n_results = 0;
  int             errors = 0;
  int             send_left = 0;
  int             stall_left = 0;
  int             send_rate = 1;
  int             recv_rate = 1;
  int             cyc = 0;
  bit             pause_done = 0;
  bit             long_done = 0;
  bit             calm;

  assign calm = beat_q.size() < CALM_TAIL;

  initial begin
    for (int i = 0; i < fsc_pkg::NUM_PLANES; i++) begin
      plane_n[i] = '{0, 0, 0};
      plane_d[i] = 0;
    end
  end

  // Visibility of one sphere against the current plane store, all terms at 2^-30.
  function automatic logic sphere_visible(fsc_pkg::beat_t b);
    longint cx, cy, cz, r30, s;
    logic   vis;
    cx  = longint'($signed(b.center_x));
    cy  = longint'($signed(b.center_y));
    cz  = longint'($signed(b.center_z));
    r30 = longint'({1'b0, b.sphere_radius}) <<< fsc_pkg::FRAC_SHIFT;
    vis = 1'b1;
    for (int i = 0; i < fsc_pkg::NUM_PLANES; i++) begin
      s = plane_n[i][0] * cx + plane_n[i][1] * cy + plane_n[i][2] * cz;
      s = s - (plane_d[i] <<< fsc_pkg::FRAC_SHIFT) + r30;
      if (s < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  // Update the plane store or queue the expected visibility for one accepted beat.
  task automatic track_beat(fsc_pkg::beat_t b);
    int idx;
    idx = int'(b.plane_index);
    if (b.cmd == fsc_pkg::CMD_LOAD) begin
      if (idx < fsc_pkg::NUM_PLANES) begin
        plane_n[idx][0] = longint'($signed(b.normal_x));
        plane_n[idx][1] = longint'($signed(b.normal_y));
        plane_n[idx][2] = longint'($signed(b.normal_z));
        plane_d[idx]    = longint'($signed(b.plane_offset));
      end
    end else begin
      visible_q.push_back(sphere_visible(b));
    end
  endtask

  // Unused fields of each beat carry random junk.
  task automatic push_load(int idx, int nx, int ny, int nz, int off);
    fsc_pkg::beat_t b;
    b.cmd           = fsc_pkg::CMD_LOAD;
    b.plane_index   = idx[fsc_pkg::IDX_W-1:0];
    b.normal_x      = nx[fsc_pkg::NORM_W-1:0];
    b.normal_y      = ny[fsc_pkg::NORM_W-1:0];
    b.normal_z      = nz[fsc_pkg::NORM_W-1:0];
    b.plane_offset  = off;
    b.center_x      = $urandom;
    b.center_y      = $urandom;
    b.center_z      = $urandom;
    b.sphere_radius = fsc_pkg::RAD_W'($urandom);
    b.visible       = 1'b0;
    beat_q.push_back(b);
    if (idx < fsc_pkg::NUM_PLANES) n_beats++;
  endtask

  task automatic push_test(int cx, int cy, int cz, int r);
    fsc_pkg::beat_t b;
    b.cmd           = fsc_pkg::CMD_TEST;
    b.plane_index   = fsc_pkg::IDX_W'($urandom);
    b.normal_x      = fsc_pkg::NORM_W'($urandom);
    b.normal_y      = fsc_pkg::NORM_W'($urandom);
    b.normal_z      = fsc_pkg::NORM_W'($urandom);
    b.plane_offset  = $urandom;
    b.center_x      = cx;
    b.center_y      = cy;
    b.center_z      = cz;
    b.sphere_radius = r[fsc_pkg::RAD_W-1:0];
    b.visible       = 1'b0;
    beat_q.push_back(b);
    n_beats++;
  endtask

  task automatic push_plane_set();
    int style, h, ax, sg;
    int nv[3];
    style = $urandom_range(0, 3);
    h = $urandom_range(32'h0001_0000, 32'h0010_0000);
    for (int i = 0; i < fsc_pkg::NUM_PLANES; i++) begin
      unique case (style)
        0: begin
          // axis-aligned box of half size h
          ax = i / 2;
          sg = (i % 2) ? -16384 : 16384;
          nv = '{0, 0, 0};
          nv[ax] = sg;
          push_load(i, nv[0], nv[1], nv[2], -h);
        end
        1: begin
          push_load(i, $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 2 * h) - h);
        end
        2: begin
          push_load(i, $urandom, $urandom, $urandom, $urandom);
        end
        default: begin
          // leave some planes empty
          if ($urandom_range(0, 1)) push_load(i, 0, 0, 0, 0);
          else push_load(i, $urandom_range(0, 32768) - 16384, 0, 0, -h);
        end
      endcase
    end
  endtask

  task automatic fill_stimulus();
    int pick;
    // no planes loaded: everything visible
    push_test(CMIN, CMAX, CMIN, 0);
    push_load(0, 16384, 0, 0, 0);
    push_test(-1, 0, 0, 0);
    push_test(0, 0, 0, 0);          // sum exactly zero
    push_test(-5, CMAX, CMIN, 5);   // zero again via the radius
    push_test(-6, 0, 0, 5);
    // out-of-range loads must leave plane zero alone
    push_load(6, -16384, 0, 0, CMAX);
    push_load(7, -32768, 32767, -32768, CMIN);
    push_test(-1, 0, 0, 0);
    push_load(1, -32768, -32768, -32768, CMIN);
    push_load(2, 32767, 32767, 32767, CMAX);
    push_load(3, 0, -32768, 32767, 0);
    push_load(4, 1, -1, 0, -1);
    push_load(5, 0, 0, 0, 0);
    push_test(CMAX, CMAX, CMAX, CMAX);
    push_test(CMIN, CMIN, CMIN, CMAX);
    push_test(0, 0, 0, 0);
    push_test(CMAX, CMIN, CMAX, 0);
    push_test(CMIN, CMAX, 0, CMAX);
    push_load(0, 0, 0, 0, 0);
    push_load(1, 0, 0, 0, 0);
    push_load(2, -32768, 0, 0, CMIN);
    push_test(0, 0, 0, CMAX);
    push_test(CMAX, 0, 0, 0);

    while (n_beats < TOTAL_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_plane_set();
      end else if (pick < 12) begin
        push_load($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 75) begin
        push_test($urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                  $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                  $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                  $urandom_range(0, 32'h0008_0000));
      end else begin
        push_test($urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic note_mismatch(string what, logic want, logic got);
    errors++;
    if (errors <= 10)
      $display("mismatch at %0t: %s, expected visible=%b, got visible=%b", $realtime, what,
               want, got);
  endtask

  // Pick idle rates per window; rate zero gives stretches with no idling.
  always @(posedge clk) begin
    cyc++;
    if (cyc % 64 == 0) begin
      send_rate = $urandom_range(0, 3);
      recv_rate = $urandom_range(0, 3);
    end
  end

  // Sender: hold a stalled beat, otherwise offer the next pending beat or idle.
  always @(posedge clk) begin : drive_beats
    logic offer;
    offer = 1'b0;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && item_stall)) begin
      if (item_valid) begin
        track_beat(cur_beat);
        n_sent++;
      end
      if (send_left > 0) begin
        send_left--;
      end else if (n_sent == PAUSE_AT && !pause_done) begin
        // drain every outstanding result before going on
        if (visible_q.size() == 0) pause_done = 1;
      end else if (beat_q.size() != 0) begin
        if (!calm && $urandom_range(0, 15) < 2 * send_rate)
          send_left = $urandom_range(1, 14) - 1;
        else
          offer = 1'b1;
      end
      if (offer) begin
        cur_beat = beat_q.pop_front();
        cmd           <= cur_beat.cmd;
        plane_index   <= cur_beat.plane_index;
        normal_x      <= cur_beat.normal_x;
        normal_y      <= cur_beat.normal_y;
        normal_z      <= cur_beat.normal_z;
        plane_offset  <= cur_beat.plane_offset;
        center_x      <= cur_beat.center_x;
        center_y      <= cur_beat.center_y;
        center_z      <= cur_beat.center_z;
        sphere_radius <= cur_beat.sphere_radius;
      end
      item_valid <= offer;
    end
  end

  // Receiver stall: random bursts plus one long hold that backs up the pipeline.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (!long_done && n_results >= LONG_AT) begin
        long_done = 1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) < 2 * recv_rate) begin
        stall_left = $urandom_range(1, 14) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    logic want;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (visible_q.size() == 0) begin
        note_mismatch("result with nothing expected", 1'bx, visible);
      end else begin
        want = visible_q.pop_front();
        if (visible !== want) note_mismatch("visible", want, visible);
      end
    end
  end

  initial begin
    fill_stimulus();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (beat_q.size() != 0 || item_valid) @(posedge clk);
    while (visible_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && visible_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
